// ----- sv/bts_pkg.sv -----
// Shared types and constants of the button-toggled output sequencer.
`timescale 1ns / 1ps
`default_nettype none

package bts_pkg;

    localparam int unsigned NUM_OUTPUTS_DEF = 8;

    localparam logic [15:0] STEP_DELAY_RST  = 16'h024C;
    localparam logic [7:0]  PRESS_THR_RST   = 8'h07;

    localparam int unsigned CFG_ADDR_W = 3;

    typedef enum logic [0:0] {
        REG_STEP_DELAY = 1'b0,
        REG_PRESS_THR  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic button_low;
    } t_tick_item;

    typedef struct packed {
        logic [7:0] output_bits;
        logic       target_on;
        logic       busy_res;
    } t_res_item;

endpackage

`default_nettype wire

// ----- sv/bts_stream_if.sv -----
// Valid/ready channel interface with a typed payload.
`timescale 1ns / 1ps
`default_nettype none

interface bts_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/button_toggled_output_sequencer.sv -----
// Top level of the button-toggled output sequencer.
//
// Each transfer on i_tick is one timer tick carrying the sampled button level.
// Every tick yields exactly one result transfer on o_res giving the output
// drive bits, the current target level and the busy flag after that tick.
// A tick is captured in an input register and its result is computed by one
// short layer of logic into the result register. The result is offered from
// the result register once its tick has passed through the input register, and
// a tick is taken in every cycle while the receiver keeps up.
// If the receiver stalls, the result register holds and one further tick may
// wait in the input register; i_tick.ready then falls until a result leaves.
// The APB port holds step_delay at address 0 and press_threshold at 4; it is
// to be written only while no ticks are in flight; the block does not enforce this.
// Synchronous reset restores the register defaults, clears the press counter,
// turns every output off and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module button_toggled_output_sequencer #(
    parameter int unsigned NUM_OUTPUTS = bts_pkg::NUM_OUTPUTS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    bts_stream_if.sink                           i_tick,
    bts_stream_if.source                         o_res,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bts_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);
    import bts_pkg::*;

    localparam int unsigned IW = $clog2(NUM_OUTPUTS + 1);
    localparam int unsigned PW = (NUM_OUTPUTS > 8) ? NUM_OUTPUTS : 8;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_SEQ  = 3'b010,
        PH_WAIT = 3'b100
    } t_phase;

    logic [15:0]            r_step_delay;
    logic [7:0]             r_press_thr;
    logic                   r_in_valid;
    t_tick_item             r_in;
    logic                   r_out_valid;
    t_res_item              r_out;
    logic [7:0]             r_count;
    t_phase                 r_phase;
    logic [IW-1:0]          r_idx;
    logic [15:0]            r_delay;
    logic                   r_level;
    logic [NUM_OUTPUTS-1:0] r_drive;

    logic [7:0]             n_count;
    t_phase                 n_phase;
    logic [IW-1:0]          n_idx;
    logic [15:0]            n_delay;
    logic                   n_level;
    logic [NUM_OUTPUTS-1:0] n_drive;

    logic                   w_advance;
    logic                   w_cfg_wr;
    t_reg_idx               w_reg;
    logic [7:0]             w_thr;
    logic [15:0]            w_eff_delay;
    logic [15:0]            w_dec;
    logic [IW-1:0]          w_idx_inc;
    logic                   w_drive_en;
    logic [PW-1:0]          w_pad;

    assign pready   = 1'b1;
    assign w_reg    = t_reg_idx'(paddr[2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (w_reg)
            REG_STEP_DELAY: prdata = {16'h0000, r_step_delay};
            REG_PRESS_THR:  prdata = {24'h000000, r_press_thr};
            default:        prdata = 32'h0000_0000;
        endcase
    end

    assign w_advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_tick.ready = !r_in_valid || w_advance;
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_out;

    assign w_thr       = (r_press_thr == 8'd0) ? 8'd1 : r_press_thr;
    assign w_eff_delay = (r_step_delay == 16'd0) ? 16'd1 : r_step_delay;
    assign w_dec       = (r_delay != 16'd0) ? r_delay - 16'd1 : r_delay;
    assign w_idx_inc   = r_idx + IW'(1);

    always_comb begin
        n_count    = r_count;
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_delay    = r_delay;
        n_level    = r_level;
        n_drive    = r_drive;
        w_drive_en = 1'b0;

        if (r_in.button_low && (r_count < w_thr)) begin
            n_count = r_count + 8'd1;
        end

        case (r_phase)
            PH_IDLE: begin
                if (n_count >= w_thr) begin
                    n_level    = !r_level;
                    n_idx      = '0;
                    w_drive_en = 1'b1;
                    n_delay    = w_eff_delay;
                    n_phase    = PH_SEQ;
                end
            end
            PH_SEQ: begin
                n_delay = w_dec;
                if (w_dec == 16'd0) begin
                    n_idx = w_idx_inc;
                    if (w_idx_inc < IW'(NUM_OUTPUTS)) begin
                        w_drive_en = 1'b1;
                        n_delay    = w_eff_delay;
                    end else begin
                        n_phase = PH_WAIT;
                    end
                end
            end
            default: begin
            end
        endcase

        if (w_drive_en) begin
            for (int k = 0; k < NUM_OUTPUTS; k++) begin
                if (n_idx == IW'(k)) begin
                    n_drive[k] = n_level;
                end
            end
        end

        if ((n_phase == PH_WAIT) && !r_in.button_low) begin
            n_count = 8'd0;
            n_idx   = '0;
            n_phase = PH_IDLE;
        end
    end

    assign w_pad = PW'(n_drive);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_delay <= STEP_DELAY_RST;
            r_press_thr  <= PRESS_THR_RST;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_count      <= 8'd0;
            r_phase      <= PH_IDLE;
            r_idx        <= '0;
            r_delay      <= 16'd0;
            r_level      <= 1'b0;
            r_drive      <= '0;
        end else begin
            if (w_cfg_wr) begin
                case (w_reg)
                    REG_STEP_DELAY: r_step_delay <= pwdata[15:0];
                    REG_PRESS_THR:  r_press_thr  <= pwdata[7:0];
                    default: begin
                    end
                endcase
            end

            if (i_tick.valid && i_tick.ready) begin
                r_in_valid <= 1'b1;
                r_in       <= i_tick.data;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end

            if (w_advance) begin
                r_out_valid       <= 1'b1;
                r_out.output_bits <= w_pad[7:0];
                r_out.target_on   <= n_level;
                r_out.busy_res    <= (n_phase != PH_IDLE);
                r_count           <= n_count;
                r_phase           <= n_phase;
                r_idx             <= n_idx;
                r_delay           <= n_delay;
                r_level           <= n_level;
                r_drive           <= n_drive;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the button-toggled output sequencer.
`timescale 1ns / 1ps

module testbench;
    import bts_pkg::*;

    localparam int NUM_OUT = NUM_OUTPUTS_DEF;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_RELEASE
    } t_seq_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bts_stream_if #(.T(t_tick_item)) tick_if ();
    bts_stream_if #(.T(t_res_item))  res_if ();

    logic [15:0] cfg_step_delay;
    logic [7:0]  cfg_press_thr;
    logic [7:0]  press_cnt;
    t_seq_phase  seq_phase;
    int          seq_step;
    int          seq_delay_left;
    logic        seq_level;
    logic [7:0]  seq_drive;

    t_res_item   due_outputs[$];
    t_res_item   due_head;
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          settle;

    button_toggled_output_sequencer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_res_item advance_sequencer(input logic pressed);
        int        thr;
        int        dly;
        t_res_item r;
        thr = (cfg_press_thr == 8'd0) ? 1 : int'(cfg_press_thr);
        dly = (cfg_step_delay == 16'd0) ? 1 : int'(cfg_step_delay);
        if (pressed && int'(press_cnt) < thr) begin
            press_cnt = press_cnt + 8'd1;
        end
        case (seq_phase)
            SEQ_IDLE: begin
                if (int'(press_cnt) >= thr) begin
                    seq_level      = ~seq_level;
                    seq_step       = 0;
                    seq_drive[0]   = seq_level;
                    seq_delay_left = dly;
                    seq_phase      = SEQ_RUN;
                end
            end
            SEQ_RUN: begin
                if (seq_delay_left > 0) begin
                    seq_delay_left--;
                end
                if (seq_delay_left == 0) begin
                    seq_step++;
                    if (seq_step < NUM_OUT) begin
                        seq_drive[seq_step] = seq_level;
                        seq_delay_left      = dly;
                    end else begin
                        seq_phase = SEQ_RELEASE;
                    end
                end
            end
            default: ;
        endcase
        if (seq_phase == SEQ_RELEASE && !pressed) begin
            press_cnt = 8'd0;
            seq_step  = 0;
            seq_phase = SEQ_IDLE;
        end
        r.output_bits = seq_drive;
        r.target_on   = seq_level;
        r.busy_res    = (seq_phase != SEQ_IDLE);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("Mismatch in %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    // Every accepted result is compared with the oldest outstanding prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (due_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result transfer with no tick outstanding: %0h",
                             res_if.data);
                end
            end else begin
                due_head = due_outputs.pop_front();
                if (res_if.data.output_bits !== due_head.output_bits) begin
                    flag_mismatch("output_bits", due_head.output_bits,
                                  res_if.data.output_bits);
                end
                if (res_if.data.target_on !== due_head.target_on) begin
                    flag_mismatch("target_on", due_head.target_on, res_if.data.target_on);
                end
                if (res_if.data.busy_res !== due_head.busy_res) begin
                    flag_mismatch("busy_res", due_head.busy_res, res_if.data.busy_res);
                end
            end
        end
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_tick(input logic btn);
        while ($urandom_range(99) < send_idle_pct) begin
            tick_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_if.valid <= 1'b1;
        tick_if.data  <= t_tick_item'(btn);
        do @(posedge i_clk); while (!tick_if.ready);
        due_outputs.push_back(advance_sequencer(btn));
    endtask

    task automatic wait_for_results();
        tick_if.valid <= 1'b0;
        do @(posedge i_clk); while (due_outputs.size() != 0);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        wait_for_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_STEP_DELAY) begin
            cfg_step_delay = value[15:0];
        end else begin
            cfg_press_thr = value[7:0];
        end
        @(posedge i_clk);
    endtask

    task automatic check_reg(input t_reg_idx idx, input logic [31:0] want);
        wait_for_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            flag_mismatch("register read", want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_to_idle();
        while (seq_phase != SEQ_IDLE) begin
            send_tick(seq_phase == SEQ_RUN || $urandom_range(3) == 0);
        end
    endtask

    task automatic pick_random_config();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            write_reg(REG_STEP_DELAY, 32'd0);
        end else if (pick == 1) begin
            write_reg(REG_STEP_DELAY, $urandom_range(40, 20));
        end else begin
            write_reg(REG_STEP_DELAY, $urandom_range(6, 1));
        end
        pick = $urandom_range(9);
        if (pick == 0) begin
            write_reg(REG_PRESS_THR, 32'd0);
        end else begin
            write_reg(REG_PRESS_THR, $urandom_range(12, 1));
        end
    endtask

    // Register defaults, then non-consecutive presses up to the default threshold.
    task automatic test_reset_values();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        check_reg(REG_STEP_DELAY, 32'(STEP_DELAY_RST));
        check_reg(REG_PRESS_THR, 32'(PRESS_THR_RST));
        repeat (3) send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        repeat (3) send_tick(1'b1);
        write_reg(REG_STEP_DELAY, 32'd3);
        send_tick(1'b1);
        run_to_idle();
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(REG_STEP_DELAY, 32'd0);
        write_reg(REG_PRESS_THR, 32'd0);
        send_tick(1'b0);
        // Released on the tick on which the last wait ends.
        repeat (8) send_tick(1'b1);
        send_tick(1'b0);
        // Held past the end of the sequence, then released.
        repeat (10) send_tick(1'b1);
        send_tick(1'b0);
        // Threshold lowered below the count already reached.
        write_reg(REG_PRESS_THR, 32'd10);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        write_reg(REG_PRESS_THR, 32'd3);
        send_tick(1'b0);
        run_to_idle();
    endtask

    // Largest register values read back, then the highest threshold with the
    // delay shortened part-way through the first wait.
    task automatic test_long_delay();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(REG_STEP_DELAY, 32'd65535);
        check_reg(REG_STEP_DELAY, 32'd65535);
        write_reg(REG_PRESS_THR, 32'd255);
        check_reg(REG_PRESS_THR, 32'd255);
        write_reg(REG_STEP_DELAY, 32'd30);
        while (seq_phase == SEQ_IDLE) begin
            send_tick($urandom_range(9) != 0);
        end
        repeat (5) send_tick($urandom_range(1));
        write_reg(REG_STEP_DELAY, 32'd1);
        run_to_idle();
    endtask

    task automatic test_random_traffic(input int n_ticks, input int idle_pct,
                                       input int stall_pct);
        int sent;
        int burst;
        int press_pct;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        pick_random_config();
        sent = 0;
        while (sent < n_ticks) begin
            burst = $urandom_range(40, 5);
            case ($urandom_range(9))
                0:       press_pct = 10;
                1, 2:    press_pct = 50;
                default: press_pct = 90;
            endcase
            repeat (burst) begin
                send_tick($urandom_range(99) < press_pct);
                sent++;
            end
            if (sent == burst || $urandom_range(19) == 0) begin
                wait_for_results();
            end
            if ($urandom_range(9) == 0) begin
                pick_random_config();
            end
        end
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        tick_if.valid  = 1'b0;
        tick_if.data   = '0;
        res_if.ready   = 1'b0;
        cfg_step_delay = STEP_DELAY_RST;
        cfg_press_thr  = PRESS_THR_RST;
        press_cnt      = 8'd0;
        seq_phase      = SEQ_IDLE;
        seq_step       = 0;
        seq_delay_left = 0;
        seq_level      = 1'b0;
        seq_drive      = 8'd0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_directed();
        test_long_delay();
        test_random_traffic(90, 0, 0);
        test_random_traffic(90, 45, 0);
        test_random_traffic(90, 0, 45);
        test_random_traffic(90, 38, 38);

        tick_if.valid <= 1'b0;
        settle = 0;
        while (due_outputs.size() != 0 && settle < 2000) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && due_outputs.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
